// ===== rtl/ibhp_pkg.sv =====
// ----------------------------------------------------------------------------
// ibhp_pkg
// Shared types and codes of the ISO base media box header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ibhp_pkg;

  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FTYP_MODE = 4'd1;

  localparam logic [31:0] TYPE_UUID = 32'h75756964;
  localparam logic [31:0] TYPE_FTYP = 32'h66747970;

  typedef enum logic [3:0] {
    PH_SIZE   = 4'd0,
    PH_TYPE   = 4'd1,
    PH_LARGE  = 4'd2,
    PH_UUID   = 4'd3,
    PH_MAJOR  = 4'd4,
    PH_MINOR  = 4'd5,
    PH_BRANDS = 4'd6
  } ibhp_phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_MAJOR  = 3'd1,
    KIND_MINOR  = 3'd2,
    KIND_BRAND  = 3'd3,
    KIND_ERROR  = 3'd4
  } ibhp_kind_t;

  typedef enum logic [2:0] {
    ERR_EARLY_END  = 3'd0,
    ERR_TOO_LARGE  = 3'd1,
    ERR_FTYP_SMALL = 3'd2,
    ERR_NOT_FTYP   = 3'd3,
    ERR_FTYP_LEN   = 3'd4
  } ibhp_err_t;

  typedef enum logic [1:0] {
    FORM_32  = 2'd0,
    FORM_64  = 2'd1,
    FORM_EOS = 2'd2
  } ibhp_form_t;

  typedef struct packed {
    logic [63:0] max_box_size;
    logic        ftyp_mode;
  } ibhp_cfg_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [63:0] box_size;
    logic [1:0]  size_form;
    logic [31:0] box_type;
    logic [63:0] user_type_high;
    logic [63:0] user_type_low;
    logic [31:0] word_value;
    logic [2:0]  error_code;
  } ibhp_rec_t;

endpackage

`default_nettype wire

// ===== rtl/ibhp_in_if.sv =====
// ----------------------------------------------------------------------------
// ibhp_in_if
// Byte stream channel into the box header parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface ibhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/ibhp_out_if.sv =====
// ----------------------------------------------------------------------------
// ibhp_out_if
// Record channel out of the box header parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface ibhp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [63:0] box_size;
  logic [1:0]  size_form;
  logic [31:0] box_type;
  logic [63:0] user_type_high;
  logic [63:0] user_type_low;
  logic [31:0] word_value;
  logic [2:0]  error_code;

  modport source (output valid, output record_kind, output box_size, output size_form,
                  output box_type, output user_type_high, output user_type_low,
                  output word_value, output error_code, input ready);
  modport sink   (input valid, input record_kind, input box_size, input size_form,
                  input box_type, input user_type_high, input user_type_low,
                  input word_value, input error_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/ibhp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ibhp_cfg_if
// Register write channel of the box header parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface ibhp_cfg_if;
  import ibhp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ibhp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ibhp_cfg_regs
// Configuration registers: maximum box size and file type mode.
// ----------------------------------------------------------------------------
`default_nettype none

module ibhp_cfg_regs
  import ibhp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ibhp_cfg_if.sink   cfg_ch,
  output ibhp_cfg_t  cfg
);

  logic [63:0] max_size_r;
  logic        ftyp_mode_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r  <= '1;
      ftyp_mode_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      // Writes to indexes beyond the register list are dropped.
      if (cfg_ch.index == CFG_MAX_SIZE) begin
        max_size_r <= cfg_ch.data;
      end
      if (cfg_ch.index == CFG_FTYP_MODE) begin
        ftyp_mode_r <= cfg_ch.data[0];
      end
    end
  end

  assign cfg.max_box_size = max_size_r;
  assign cfg.ftyp_mode    = ftyp_mode_r;

endmodule

`default_nettype wire

// ===== rtl/ibhp_parser.sv =====
// ----------------------------------------------------------------------------
// ibhp_parser
// Header state machine: consumes one byte per transfer and yields at most
// one record for it.
// ----------------------------------------------------------------------------
`default_nettype none

module ibhp_parser
  import ibhp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_acc,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end,
  input  ibhp_cfg_t       cfg,
  output logic            res_valid,
  output ibhp_rec_t       res
);

  ibhp_phase_t phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [63:0] size_r, size_nxt;
  logic [31:0] type_r, type_nxt;
  logic [63:0] uth_r, uth_nxt;
  logic [63:0] utl_r, utl_nxt;
  logic [31:0] word_r, word_nxt;
  logic [63:0] rem_r, rem_nxt;
  ibhp_form_t  form_r, form_nxt;

  logic [4:0]  idx_inc;
  logic        last4, last8, last16;
  logic [63:0] size32_new, size64_new;
  logic [31:0] type_new, word_new;
  logic        max_all_ones;
  logic [63:0] rem_dec;

  // Completion check operands, chosen by the phase that completes the header.
  logic [63:0] c_size, c_eff_size, c_uth, c_utl, c_rem;
  logic [31:0] c_type;
  ibhp_form_t  c_form;
  logic        c_uuid, c_small, c_bad;
  logic [5:0]  c_thr;
  ibhp_err_t   c_code;

  logic        do_fail, do_restart, do_complete, go_major;
  ibhp_err_t   fail_code;

  assign idx_inc      = {1'b0, idx_r} + 5'd1;
  assign last4        = idx_inc >= 5'd4;
  assign last8        = idx_inc >= 5'd8;
  assign last16       = idx_inc >= 5'd16;
  assign size32_new   = {32'd0, size_r[23:0], in_byte};
  assign size64_new   = {size_r[55:0], in_byte};
  assign type_new     = {type_r[23:0], in_byte};
  assign word_new     = {word_r[23:0], in_byte};
  assign max_all_ones = &cfg.max_box_size;
  assign rem_dec      = (rem_r >= 64'd4) ? (rem_r - 64'd4) : 64'd0;

  always_comb begin
    c_size = size_r;
    c_form = form_r;
    c_type = type_r;
    c_uth  = uth_r;
    c_utl  = utl_r;
    unique case (phase_r)
      PH_TYPE: begin
        c_type = type_new;
        c_form = (size_r == 64'd0) ? FORM_EOS : FORM_32;
      end
      PH_LARGE: c_size = size64_new;
      PH_UUID: begin
        if (idx_r[3]) begin
          c_utl = {utl_r[55:0], in_byte};
        end else begin
          c_uth = {uth_r[55:0], in_byte};
        end
      end
      default: ;
    endcase
  end

  // The header length plus the brand and version words is 16, 24, 32 or 40,
  // so the remainder keeps the low two bits of the size.
  assign c_eff_size = (c_form == FORM_EOS) ? 64'd0 : c_size;
  assign c_uuid     = (c_type == TYPE_UUID);
  assign c_thr      = 6'd16 + ((c_form == FORM_64) ? 6'd8 : 6'd0) + (c_uuid ? 6'd16 : 6'd0);
  assign c_small    = (c_eff_size[63:6] == 58'd0) && (c_eff_size[5:0] < c_thr);
  assign c_rem      = c_eff_size - {58'd0, c_thr};

  always_comb begin
    c_bad  = 1'b1;
    c_code = ERR_FTYP_LEN;
    if (c_form == FORM_EOS) begin
      c_code = ERR_FTYP_LEN;
    end else if (c_small) begin
      c_code = ERR_FTYP_SMALL;
    end else if (c_type != TYPE_FTYP) begin
      c_code = ERR_NOT_FTYP;
    end else if (c_eff_size[1:0] != 2'd0) begin
      c_code = ERR_FTYP_LEN;
    end else begin
      c_bad = 1'b0;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    size_nxt    = size_r;
    type_nxt    = type_r;
    uth_nxt     = uth_r;
    utl_nxt     = utl_r;
    word_nxt    = word_r;
    rem_nxt     = rem_r;
    form_nxt    = form_r;
    res_valid   = 1'b0;
    res         = '0;
    do_fail     = 1'b0;
    do_restart  = 1'b0;
    do_complete = 1'b0;
    go_major    = 1'b0;
    fail_code   = ERR_EARLY_END;

    if (in_acc) begin
      if (in_end) begin
        do_fail   = 1'b1;
        fail_code = ERR_EARLY_END;
      end else begin
        unique case (phase_r)
          PH_SIZE: begin
            size_nxt = size32_new;
            idx_nxt  = last4 ? 4'd0 : idx_inc[3:0];
            if (last4) begin
              if (size32_new > cfg.max_box_size) begin
                do_fail   = 1'b1;
                fail_code = ERR_TOO_LARGE;
              end else begin
                phase_nxt = PH_TYPE;
              end
            end
          end
          PH_TYPE: begin
            type_nxt = type_new;
            idx_nxt  = last4 ? 4'd0 : idx_inc[3:0];
            if (last4) begin
              form_nxt = c_form;
              if (size_r == 64'd1) begin
                form_nxt  = FORM_64;
                size_nxt  = 64'd0;
                phase_nxt = PH_LARGE;
              end else if (size_r == 64'd0 && !max_all_ones) begin
                do_fail   = 1'b1;
                fail_code = ERR_TOO_LARGE;
              end else if (type_new == TYPE_UUID) begin
                phase_nxt = PH_UUID;
              end else begin
                do_complete = 1'b1;
              end
            end
          end
          PH_LARGE: begin
            size_nxt = size64_new;
            idx_nxt  = last8 ? 4'd0 : idx_inc[3:0];
            if (last8) begin
              if (size64_new > cfg.max_box_size) begin
                do_fail   = 1'b1;
                fail_code = ERR_TOO_LARGE;
              end else if (type_r == TYPE_UUID) begin
                phase_nxt = PH_UUID;
              end else begin
                do_complete = 1'b1;
              end
            end
          end
          PH_UUID: begin
            uth_nxt     = c_uth;
            utl_nxt     = c_utl;
            idx_nxt     = last16 ? 4'd0 : idx_inc[3:0];
            do_complete = last16;
          end
          PH_MAJOR, PH_MINOR, PH_BRANDS: begin
            word_nxt = word_new;
            idx_nxt  = last4 ? 4'd0 : idx_inc[3:0];
            if (last4) begin
              res_valid      = 1'b1;
              res.word_value = word_new;
              word_nxt       = 32'd0;
              if (phase_r == PH_MAJOR) begin
                res.record_kind = KIND_MAJOR;
                phase_nxt       = PH_MINOR;
              end else if (phase_r == PH_MINOR) begin
                res.record_kind = KIND_MINOR;
                if (rem_r == 64'd0) begin
                  do_restart = 1'b1;
                end else begin
                  phase_nxt = PH_BRANDS;
                end
              end else begin
                res.record_kind = KIND_BRAND;
                rem_nxt         = rem_dec;
                do_restart      = (rem_dec == 64'd0);
              end
            end
          end
          default: do_restart = 1'b1;
        endcase
      end
    end

    if (do_complete) begin
      if (cfg.ftyp_mode && c_bad) begin
        do_fail   = 1'b1;
        fail_code = c_code;
      end else begin
        res_valid          = 1'b1;
        res.record_kind    = KIND_HEADER;
        res.box_size       = c_eff_size;
        res.size_form      = c_form;
        res.box_type       = c_type;
        res.user_type_high = c_uuid ? c_uth : 64'd0;
        res.user_type_low  = c_uuid ? c_utl : 64'd0;
        do_restart         = 1'b1;
        go_major           = cfg.ftyp_mode;
      end
    end

    if (do_fail) begin
      res_valid       = 1'b1;
      res             = '0;
      res.record_kind = KIND_ERROR;
      res.error_code  = fail_code;
      do_restart      = 1'b1;
    end

    if (do_restart) begin
      phase_nxt = PH_SIZE;
      idx_nxt   = 4'd0;
      size_nxt  = 64'd0;
      type_nxt  = 32'd0;
      uth_nxt   = 64'd0;
      utl_nxt   = 64'd0;
      word_nxt  = 32'd0;
      rem_nxt   = 64'd0;
      form_nxt  = FORM_32;
    end

    if (go_major) begin
      phase_nxt = PH_MAJOR;
      rem_nxt   = c_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      idx_r   <= 4'd0;
      size_r  <= 64'd0;
      type_r  <= 32'd0;
      uth_r   <= 64'd0;
      utl_r   <= 64'd0;
      word_r  <= 32'd0;
      rem_r   <= 64'd0;
      form_r  <= FORM_32;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      size_r  <= size_nxt;
      type_r  <= type_nxt;
      uth_r   <= uth_nxt;
      utl_r   <= utl_nxt;
      word_r  <= word_nxt;
      rem_r   <= rem_nxt;
      form_r  <= form_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ibhp_out_stage.sv =====
// ----------------------------------------------------------------------------
// ibhp_out_stage
// Result register with a skid entry, so a byte can be taken while a record
// still waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ibhp_out_stage
  import ibhp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic res_valid,
  input  ibhp_rec_t res,
  input  wire logic out_ready,
  output logic      out_valid,
  output ibhp_rec_t out_rec,
  output logic      in_ready
);

  logic      out_valid_r;
  ibhp_rec_t out_rec_r;
  logic      skid_valid_r;
  ibhp_rec_t skid_rec_r;

  // No new record can arrive while the skid entry is full.
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= res_valid;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_rec_r <= skid_rec_r;
      end
    end else if (!out_valid_r || out_ready) begin
      out_rec_r <= res;
    end else begin
      skid_rec_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/isobmff_box_header_parser.sv =====
// ----------------------------------------------------------------------------
// isobmff_box_header_parser
// ISO base media box header parser with optional file type brand listing.
// ----------------------------------------------------------------------------
// A record is registered in the output stage, via its skid entry if the output
// is stalled, before it appears. Throughput: one byte per cycle while the skid
// entry is empty; a two-entry output stage absorbs output stalls.
// Reset (synchronous, active low) returns the parser to the start of a size
// field, empties the output stage and restores the registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module isobmff_box_header_parser
  import ibhp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ibhp_in_if.sink    in_ch,
  ibhp_out_if.source out_ch,
  ibhp_cfg_if.sink   cfg_ch
);

  ibhp_cfg_t cfg;
  logic      in_acc;
  logic      in_ready;
  logic      res_valid;
  ibhp_rec_t res;
  ibhp_rec_t out_rec;

  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;

  ibhp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  ibhp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_byte   (in_ch.data_byte),
    .in_end    (in_ch.stream_end),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  ibhp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_rec   (out_rec),
    .in_ready  (in_ready)
  );

  assign out_ch.record_kind    = out_rec.record_kind;
  assign out_ch.box_size       = out_rec.box_size;
  assign out_ch.size_form      = out_rec.size_form;
  assign out_ch.box_type       = out_rec.box_type;
  assign out_ch.user_type_high = out_rec.user_type_high;
  assign out_ch.user_type_low  = out_rec.user_type_low;
  assign out_ch.word_value     = out_rec.word_value;
  assign out_ch.error_code     = out_rec.error_code;

  // Input back-pressure only happens while a record is already waiting.
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_ch.valid)
    else $error("input stalled with no record at the output");

  // An end-of-stream transfer always leaves a valid record at the output next cycle.
  a_end_gives_record: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.stream_end) |=> out_ch.valid)
    else $error("end of stream produced no record");

  // Only header records carry size and type fields.
  a_nonheader_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_rec.record_kind != KIND_HEADER) |->
      (out_rec.box_size == 64'd0 && out_rec.box_type == 32'd0 &&
       out_rec.size_form == FORM_32))
    else $error("non-header record carries header fields");

  // Error codes appear in error records only.
  a_err_only_in_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_rec.record_kind != KIND_ERROR) |->
      (out_rec.error_code == ERR_EARLY_END))
    else $error("error code set outside an error record");

endmodule

`default_nettype wire
